@@ rtl/kwm_pkg.sv @@
package kwm_pkg;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED   = 3'd0,
        ST_POPPED     = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_IN_USE = 3'd4
    } status_t;

    // branch conditions of the microprogram
    typedef enum logic [1:0] {
        C_ALWAYS = 2'd0,
        C_NEVER  = 2'd1,
        C_WAIT   = 2'd2,
        C_MORE   = 2'd3
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_APPEND = 3'd1;
    localparam step_t STEP_SCAN   = 3'd2;
    localparam step_t STEP_DRAIN  = 3'd3;
    localparam step_t STEP_FINISH = 3'd4;

    typedef struct packed {
        logic  latch;
        logic  append;
        logic  scan;
        logic  finish;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // microprogram rom
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = '{latch: 1'b0, append: 1'b0, scan: 1'b0, finish: 1'b0,
              cond: C_ALWAYS, target: STEP_IDLE};
        unique case (s)
            STEP_IDLE:
            begin
                w.latch  = 1'b1;
                w.cond   = C_WAIT;
                w.target = STEP_SCAN;
            end
            STEP_APPEND:
            begin
                w.append = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
            STEP_SCAN:
            begin
                w.scan   = 1'b1;
                w.cond   = C_MORE;
                w.target = STEP_SCAN;
            end
            STEP_DRAIN:
            begin
                w.cond   = C_NEVER;
                w.target = STEP_IDLE;
            end
            STEP_FINISH:
            begin
                w.finish = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/kwm_sequencer.sv @@
module kwm_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            op,
    input  logic            more,
    output kwm_pkg::ctrl_t  ctrl,
    output logic            busy
);
    import kwm_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    ctrl_t word;

    always_comb
    begin
        word       = ucode(upc_reg);
        ctrl       = word;
        ctrl.latch = word.latch & start;
    end

    always_comb
    begin
        upc_next = upc_reg + 3'd1;
        unique case (word.cond)
            C_ALWAYS:
            begin
                upc_next = word.target;
            end
            C_NEVER:
            begin
                upc_next = upc_reg + 3'd1;
            end
            C_WAIT:
            begin
                priority if (!start)
                    upc_next = upc_reg;
                else if (op == OP_POP)
                    upc_next = word.target;
                else
                    upc_next = upc_reg + 3'd1;
            end
            C_MORE:
            begin
                upc_next = more ? word.target : upc_reg + 3'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign busy = (upc_reg != STEP_IDLE);

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= STEP_FINISH)
        else $error("step counter outside program");

    a_pop_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && op == OP_POP) |=> (upc_reg == STEP_SCAN))
        else $error("pop transfer did not enter scan");

    a_append_enters_append: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && op == OP_APPEND) |=> (upc_reg == STEP_APPEND))
        else $error("append transfer did not enter append step");

endmodule

@@ rtl/kwm_datapath.sv @@
module kwm_datapath #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kwm_pkg::ctrl_t                      ctrl,
    input  logic [kwm_pkg::INDEX_W-1:0]         list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  value,
    input  logic                                cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]           cfg_data,
    output logic                                more,
    output logic                                done,
    output logic [kwm_pkg::STATUS_W-1:0]        status,
    output logic signed [kwm_pkg::VALUE_W-1:0]  result_value,
    output logic [kwm_pkg::INDEX_W-1:0]         source_list
);
    import kwm_pkg::*;

    localparam int LW        = $clog2(NUM_LISTS);
    localparam int NW        = $clog2(NUM_LISTS + 1);
    localparam int CMPW      = (NW > CFG_W) ? NW : CFG_W;
    localparam int CW        = $clog2(2 * LIST_DEPTH);
    localparam int SW        = $clog2(LIST_DEPTH);
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(2 * LIST_DEPTH - 1);
    localparam logic [CW:0]   TWO_D_C = (CW+1)'(2 * LIST_DEPTH);
    localparam logic [AW-1:0] STRIDE  = AW'(LIST_DEPTH);

    function automatic logic [SW-1:0] slot_of(input logic [CW-1:0] c);
        return (c >= DEPTH_C) ? SW'(c - DEPTH_C) : SW'(c);
    endfunction

    function automatic logic [CW-1:0] advance(input logic [CW-1:0] c);
        return (c == LAST_C) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [CW-1:0] occupancy(input logic [CW-1:0] t,
                                                input logic [CW-1:0] h);
        return (t >= h) ? (t - h) : CW'((CW+1)'(t) + TWO_D_C - (CW+1)'(h));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l,
                                              input logic [SW-1:0] s);
        return AW'(l) * STRIDE + AW'(s);
    endfunction

    logic [CFG_W-1:0]        cfg_reg;
    logic [CW-1:0]           tail_reg [NUM_LISTS];
    logic [CW-1:0]           head_reg [NUM_LISTS];
    logic [LW-1:0]           ptr_reg;
    logic                    pend_valid_reg;
    logic [LW-1:0]           pend_idx_reg;
    logic                    found_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [LW-1:0]           best_idx_reg;
    logic [INDEX_W-1:0]      idx_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [VALUE_W-1:0] mem [MEM_DEPTH];
    logic                    done_reg;
    status_t                 status_reg;
    logic signed [VALUE_W-1:0] result_value_reg;
    logic [INDEX_W-1:0]      source_list_reg;

    logic [NW-1:0]           n_active;
    logic [LW-1:0]           idx_l;
    logic                    in_use;
    logic                    app_full;
    logic                    mem_we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic                    ptr_in;
    logic                    ptr_nonempty;
    logic                    cmp_take;

    always_comb
    begin
        n_active = (CMPW'(cfg_reg) > CMPW'(NUM_LISTS)) ? NW'(NUM_LISTS) : NW'(cfg_reg);
        idx_l    = LW'(idx_reg);
        in_use   = CMPW'(idx_reg) < CMPW'(n_active);
        app_full = occupancy(tail_reg[idx_l], head_reg[idx_l]) >= DEPTH_C;
        mem_we   = ctrl.append && in_use && !app_full;
        waddr    = addr_of(idx_l, slot_of(tail_reg[idx_l]));
        raddr    = addr_of(ptr_reg, slot_of(head_reg[ptr_reg]));
        ptr_in       = NW'(ptr_reg) < n_active;
        ptr_nonempty = tail_reg[ptr_reg] != head_reg[ptr_reg];
        more     = (NW'(ptr_reg) + NW'(1)) < n_active;
        cmp_take = pend_valid_reg && (!found_reg || (rd_data_reg <= best_val_reg));
    end

    // element store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= val_reg;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            tail_reg       <= '{default: '0};
            head_reg       <= '{default: '0};
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg       <= ctrl.append || ctrl.finish;
            pend_valid_reg <= ctrl.scan && ptr_in && ptr_nonempty;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (ctrl.latch)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (ctrl.scan && more)
            begin
                ptr_reg <= ptr_reg + LW'(1);
            end
            if (cmp_take)
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.append)
            begin
                if (mem_we)
                begin
                    tail_reg[idx_l] <= advance(tail_reg[idx_l]);
                end
            end
            if (ctrl.finish)
            begin
                if (found_reg)
                begin
                    head_reg[best_idx_reg] <= advance(head_reg[best_idx_reg]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            idx_reg <= list_index;
            val_reg <= value;
        end
        if (ctrl.scan)
        begin
            pend_idx_reg <= ptr_reg;
        end
        // later list wins on equal heads
        if (cmp_take)
        begin
            best_val_reg <= rd_data_reg;
            best_idx_reg <= pend_idx_reg;
        end
        if (ctrl.append)
        begin
            priority if (!in_use)
                status_reg <= ST_NOT_IN_USE;
            else if (app_full)
                status_reg <= ST_FULL;
            else
                status_reg <= ST_APPENDED;
            result_value_reg <= '0;
            source_list_reg  <= '0;
        end
        if (ctrl.finish)
        begin
            if (found_reg)
            begin
                status_reg       <= ST_POPPED;
                result_value_reg <= best_val_reg;
                source_list_reg  <= INDEX_W'(best_idx_reg);
            end
            else
            begin
                status_reg       <= ST_EMPTY;
                result_value_reg <= '0;
                source_list_reg  <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_value_reg;
    assign source_list  = source_list_reg;

    a_pend_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(ctrl.scan))
        else $error("compare without a scan read");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(ctrl.append || ctrl.finish))
        else $error("strobe without append or finish step");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ptr_reg) < NUM_LISTS)
        else $error("scan pointer beyond lists");

endmodule

@@ rtl/k_way_sorted_merge_top.sv @@
// channel   signals                                   transfer when
// input     start, busy, op, list_index, value        start && !busy
// result    done, status, result_value, source_list   done (one cycle, no stall)
// config    cfg_valid, cfg_ready, lists_in_use        cfg_valid && cfg_ready
//
// append: the append step follows the accepting edge and registers done; busy during that step
// pop: scan over the lists in use (at least one), drain, finish, then done; the scan
// reads one head per cycle through the single read port of the element store
// a new item may be started in the cycle done is high
// reset is asynchronous; all lists empty, lists_in_use = 8, store not cleared
module k_way_sorted_merge_top #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [kwm_pkg::INDEX_W-1:0]         list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0]  value,
    output logic                                done,
    output logic [kwm_pkg::STATUS_W-1:0]        status,
    output logic signed [kwm_pkg::VALUE_W-1:0]  result_value,
    output logic [kwm_pkg::INDEX_W-1:0]         source_list,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]           lists_in_use
);
    import kwm_pkg::*;

    ctrl_t ctrl;
    logic  more;
    logic  cfg_we;

    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    kwm_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .more  (more),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    kwm_datapath #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .list_index   (list_index),
        .value        (value),
        .cfg_we       (cfg_we),
        .cfg_data     (lists_in_use),
        .more         (more),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .source_list  (source_list)
    );

endmodule

@@ sim/tb_k_way_sorted_merge_top.sv @@
`timescale 1ns / 100ps

module tb_k_way_sorted_merge_top;
    import kwm_pkg::*;

    localparam int LISTS        = NUM_LISTS_DEF;
    localparam int DEPTH        = LIST_DEPTH_DEF;
    localparam int CNT_W        = $clog2(2 * DEPTH);
    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 40;
    localparam int DIR_N        = 28;

    typedef struct packed {
        status_t                     status;
        logic signed [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]          source;
    } merge_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // config rows carry the register value in val
    typedef struct packed {
        row_kind_t                   kind;
        logic                        op;
        logic [INDEX_W-1:0]          idx;
        logic signed [VALUE_W-1:0]   val;
        logic                        typed;
        merge_result_t               want;
    } stim_row_t;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} phase_flavor_t;

    localparam merge_result_t PREDICTED = '{ST_APPENDED, 32'sd0, 3'd0};

    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b1, '{ST_EMPTY, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_APPEND, 3'd7, 32'sh7fffffff,    1'b1, '{ST_APPENDED, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_APPEND, 3'd0, 32'sh80000000,    1'b1, '{ST_APPENDED, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_APPEND, 3'd3, -32'sd1,          1'b1, '{ST_APPENDED, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_POP,    3'd5, 32'sd77,          1'b1,
          '{ST_POPPED, 32'sh80000000, 3'd0}},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b1, '{ST_POPPED, -32'sd1, 3'd3}},
        '{ROW_ITEM, OP_APPEND, 3'd2, 32'sd5,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_APPEND, 3'd6, 32'sd5,           1'b0, PREDICTED},
        // equal heads: higher list wins
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        // shrink: list 7 keeps its value but leaves the merge
        '{ROW_CFG,  OP_APPEND, 3'd0, 32'sd2,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b1, '{ST_EMPTY, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_APPEND, 3'd2, 32'sd1,           1'b1, '{ST_NOT_IN_USE, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_APPEND, 3'd1, 32'sd0,           1'b0, PREDICTED},
        // no list in use
        '{ROW_CFG,  OP_APPEND, 3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_APPEND, 3'd0, 32'sd123,         1'b1, '{ST_NOT_IN_USE, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b1, '{ST_EMPTY, 32'sd0, 3'd0}},
        // above the list count: saturates, list 7 comes back
        '{ROW_CFG,  OP_APPEND, 3'd0, 32'sd15,          1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_APPEND, 3'd7, 32'sh55555555,    1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_CFG,  OP_APPEND, 3'd0, 32'sd1,           1'b0, PREDICTED},
        '{ROW_ITEM, OP_APPEND, 3'd0, 32'shaaaaaaaa,    1'b0, PREDICTED},
        '{ROW_ITEM, OP_APPEND, 3'd1, -32'sd5,          1'b1, '{ST_NOT_IN_USE, 32'sd0, 3'd0}},
        '{ROW_ITEM, OP_POP,    3'd0, 32'sd0,           1'b0, PREDICTED},
        '{ROW_CFG,  OP_APPEND, 3'd0, 32'sd8,           1'b0, PREDICTED}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        op;
    logic [INDEX_W-1:0]          list_index;
    logic signed [VALUE_W-1:0]   value;
    logic                        done;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   result_value;
    logic [INDEX_W-1:0]          source_list;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_W-1:0]            lists_in_use;

    // merge state as the testbench sees it
    logic signed [VALUE_W-1:0]   list_mem [LISTS][DEPTH];
    logic [CNT_W-1:0]            wr_count [LISTS];
    logic [CNT_W-1:0]            rd_count [LISTS];
    logic [CFG_W-1:0]            model_lists;

    merge_result_t               pending_results [$];
    int                          mismatch_count;
    int                          items_sent;
    int                          cycle_count;

    k_way_sorted_merge_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .list_index   (list_index),
        .value        (value),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .source_list  (source_list),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .lists_in_use (lists_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic merge_result_t predict_merge(input logic op_i,
                                                    input logic [INDEX_W-1:0] idx_i,
                                                    input logic signed [VALUE_W-1:0] val_i);
        merge_result_t               res;
        int                          active;
        int                          best;
        logic                        found;
        logic signed [VALUE_W-1:0]   best_val;
        logic signed [VALUE_W-1:0]   head;
        logic [CNT_W-1:0]            fill;
        res      = '{ST_APPENDED, 32'sd0, 3'd0};
        active   = (model_lists > LISTS) ? LISTS : int'(model_lists);
        best     = 0;
        found    = 1'b0;
        best_val = '0;
        if (op_i == OP_APPEND)
        begin
            fill = wr_count[idx_i] - rd_count[idx_i];
            if (idx_i >= active)
                res.status = ST_NOT_IN_USE;
            else if (fill >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                list_mem[idx_i][wr_count[idx_i] % DEPTH] = val_i;
                wr_count[idx_i] = wr_count[idx_i] + 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < active; i++)
            begin
                fill = wr_count[i] - rd_count[i];
                if (fill != 0)
                begin
                    head = list_mem[i][rd_count[i] % DEPTH];
                    // ties go to the higher list
                    if (!found || head <= best_val)
                    begin
                        best_val = head;
                        best     = i;
                        found    = 1'b1;
                    end
                end
            end
            if (!found)
                res.status = ST_EMPTY;
            else
            begin
                res.status = ST_POPPED;
                res.value  = best_val;
                res.source = best[INDEX_W-1:0];
                rd_count[best] = rd_count[best] + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic drive_item(input logic op_i, input logic [INDEX_W-1:0] idx_i,
                              input logic signed [VALUE_W-1:0] val_i, input int gap,
                              input logic typed, input merge_result_t want);
        merge_result_t predicted;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        op         <= op_i;
        list_index <= idx_i;
        value      <= val_i;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = predict_merge(op_i, idx_i, val_i);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        items_sent++;
    endtask

    // stop sending and let every pending result come back
    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_lists_in_use(input logic [CFG_W-1:0] cfg);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        lists_in_use <= cfg;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        model_lists = cfg;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        merge_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_mismatch($sformatf("unexpected result status %0d value %0d list %0d",
                                        status, result_value, source_list));
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            status, exp_r.status));
                if (result_value !== exp_r.value)
                    note_mismatch($sformatf("result_value %0d, expected %0d",
                                            result_value, exp_r.value));
                if (source_list !== exp_r.source)
                    note_mismatch($sformatf("source_list %0d, expected %0d",
                                            source_list, exp_r.source));
            end
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] next_val [LISTS];
        logic [VALUE_W-1:0]        base;
        logic [CFG_W-1:0]          cfg;
        phase_flavor_t             flavor;
        int                        active;
        int                        focus;
        int                        phase_len;
        int                        append_pct;
        int                        gap;
        bit                        no_idle;
        logic                      op_r;
        logic [INDEX_W-1:0]        idx_r;
        logic signed [VALUE_W-1:0] val_r;

        mismatch_count = 0;
        items_sent     = 0;
        model_lists    = CFG_RESET;
        for (int i = 0; i < LISTS; i++)
        begin
            wr_count[i] = '0;
            rd_count[i] = '0;
        end

        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_APPEND;
        list_index   = '0;
        value        = '0;
        cfg_valid    = 1'b0;
        lists_in_use = CFG_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_N; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                settle_idle();
                write_lists_in_use(DIR_ROWS[r].val[CFG_W-1:0]);
            end
            else
                drive_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].val,
                           $urandom_range(0, 6), DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        // random phases, each under its own list count
        while (items_sent < ITEM_TARGET)
        begin
            settle_idle();
            case ($urandom_range(0, 9))
                0:       cfg = 4'd0;
                1:       cfg = 4'd1;
                2, 3:    cfg = 4'd8;
                4:       cfg = 4'd15;
                default: cfg = CFG_W'($urandom_range(1, 15));
            endcase
            write_lists_in_use(cfg);
            active    = (cfg > LISTS) ? LISTS : int'(cfg);
            flavor    = phase_flavor_t'($urandom_range(0, 3));
            phase_len = (flavor == PH_FILL) ? $urandom_range(80, 160) : $urandom_range(30, 90);
            focus     = $urandom_range(0, (active == 0) ? 0 : active - 1);
            no_idle   = ($urandom_range(0, 3) == 0);
            case (flavor)
                PH_FILL:  append_pct = 90;
                PH_MIX:   append_pct = 55;
                default:  append_pct = 25;
            endcase
            base = $urandom;
            for (int i = 0; i < LISTS; i++)
                next_val[i] = base + $urandom_range(0, 8);

            for (int k = 0; k < phase_len && items_sent < ITEM_TARGET; k++)
            begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
                if (flavor == PH_NOISE)
                begin
                    op_r  = 1'($urandom_range(0, 1));
                    idx_r = INDEX_W'($urandom_range(0, 7));
                    val_r = $urandom;
                end
                else
                begin
                    op_r = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_POP;
                    if (flavor == PH_FILL && $urandom_range(0, 9) < 8)
                        idx_r = INDEX_W'(focus);
                    else
                        idx_r = INDEX_W'($urandom_range(0, 7));
                    // ascending per list with small steps so heads often tie
                    if ($urandom_range(0, 9) == 0)
                        val_r = $urandom;
                    else
                    begin
                        next_val[idx_r] = next_val[idx_r] + $urandom_range(0, 3);
                        val_r = next_val[idx_r];
                    end
                end
                drive_item(op_r, idx_r, val_r, gap, 1'b0, PREDICTED);
            end
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never came", pending_results.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
